/* design/amenv_pkg.sv */
package amenv_pkg;

    localparam int unsigned LevelWidth = 8;
    localparam int unsigned HoldWidth  = 16;
    localparam int unsigned WordWidth  = 16;
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 16;

    typedef logic [LevelWidth-1:0] level_t;
    typedef logic [HoldWidth-1:0]  hold_t;

    typedef enum logic [2:0] {
        STG_ATTACK1 = 3'd0,
        STG_ATTACK2 = 3'd1,
        STG_DECAY   = 3'd2,
        STG_SUSTAIN = 3'd3,
        STG_RELEASE = 3'd4
    } stage_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_START_LEVEL  = 3'd0,
        CFG_ATTACK_ONE   = 3'd1,
        CFG_ATTACK_TWO   = 3'd2,
        CFG_DECAY        = 3'd3,
        CFG_HOLD_TICKS   = 3'd4,
        CFG_RELEASE_STEP = 3'd5
    } cfg_index_t;

    typedef struct packed {
        level_t level;
        logic   reached;
    } ramp_t;

    function automatic ramp_t ramp_toward(level_t lvl, level_t target, level_t step);
        logic [LevelWidth:0] sum;
        level_t v;
        ramp_t  r;
        sum = {1'b0, lvl} + {1'b0, step};
        if (target > lvl) begin
            v = (sum > {1'b0, target}) ? target : sum[LevelWidth-1:0];
        end
        else begin
            v = (lvl >= step) ? level_t'(lvl - step) : '0;
            if (v < target) begin
                v = target;
            end
        end
        r.level   = v;
        r.reached = (v == target);
        return r;
    endfunction

endpackage

/* design/amenv_if.sv */
interface amenv_tick_if;
    logic valid;
    logic ready;
    logic row_start;
    logic note_event;
    logic slide_to_note;
    logic instrument_event;

    modport source (output valid, output row_start, output note_event,
                    output slide_to_note, output instrument_event, input ready);
    modport sink   (input valid, input row_start, input note_event,
                    input slide_to_note, input instrument_event, output ready);
endinterface

interface amenv_env_if import amenv_pkg::*;;
    logic   valid;
    logic   ready;
    level_t envelope_volume;
    logic [2:0] envelope_stage;

    modport source (output valid, output envelope_volume, output envelope_stage,
                    input ready);
    modport sink   (input valid, input envelope_volume, input envelope_stage,
                    output ready);
endinterface

interface amenv_cfg_if import amenv_pkg::*;;
    logic valid;
    logic ready;
    logic [CfgIndexWidth-1:0] index;
    logic [CfgDataWidth-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/am_envelope_generator_unit.sv */
// channel | dir | payload                                          | word
// tick    | in  | row_start, note_event, slide_to_note, instrument | one tick
// env     | out | envelope_volume[7:0], envelope_stage[2:0]        | one result
// cfg     | in  | index[2:0], data[15:0]                           | one register
//
// One tick per cycle while tick.ready is high. At the accepting edge the state
// updates and the result is registered into the output register or the skid.
// A two-entry output buffer (output register plus skid) lets a tick be taken
// while a result waits; tick.ready drops only when both entries are full.
// cfg is always ready. Reset: volume 0, release stage, registers 0.
module am_envelope_generator_unit
    import amenv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    amenv_tick_if.sink  tick,
    amenv_env_if.source env,
    amenv_cfg_if.sink   cfg
);

    level_t             start_level_reg;
    logic [WordWidth-1:0] attack_one_reg;
    logic [WordWidth-1:0] attack_two_reg;
    logic [WordWidth-1:0] decay_reg;
    hold_t              hold_ticks_reg;
    level_t             release_step_reg;

    level_t level_reg, level_next;
    hold_t  hold_reg, hold_next;
    stage_t stage_reg, stage_next;

    level_t out_level_reg;
    stage_t out_stage_reg;
    logic   out_valid_reg;
    level_t skid_level_reg;
    stage_t skid_stage_reg;
    logic   skid_valid_reg;

    logic   accept;
    logic   take;
    level_t trig_level;
    hold_t  trig_hold;
    stage_t trig_stage;
    ramp_t  ramp;

    assign cfg.ready = 1'b1;
    assign tick.ready = !skid_valid_reg;
    assign accept = tick.valid && tick.ready;
    assign take = out_valid_reg && env.ready;

    assign env.valid = out_valid_reg;
    assign env.envelope_volume = out_level_reg;
    assign env.envelope_stage = out_stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_level_reg  <= '0;
            attack_one_reg   <= '0;
            attack_two_reg   <= '0;
            decay_reg        <= '0;
            hold_ticks_reg   <= '0;
            release_step_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_START_LEVEL:  start_level_reg  <= cfg.data[LevelWidth-1:0];
                CFG_ATTACK_ONE:   attack_one_reg   <= cfg.data;
                CFG_ATTACK_TWO:   attack_two_reg   <= cfg.data;
                CFG_DECAY:        decay_reg        <= cfg.data;
                CFG_HOLD_TICKS:   hold_ticks_reg   <= cfg.data;
                CFG_RELEASE_STEP: release_step_reg <= cfg.data[LevelWidth-1:0];
                default: ;
            endcase
        end
    end

    // row triggers
    always_comb
    begin
        trig_level = level_reg;
        trig_hold  = hold_reg;
        trig_stage = stage_reg;
        if (tick.row_start)
        begin
            if (tick.note_event && !tick.slide_to_note)
            begin
                trig_level = start_level_reg;
                trig_hold  = hold_ticks_reg;
                trig_stage = STG_ATTACK1;
            end
            else if (tick.instrument_event)
            begin
                trig_level = '0;
                trig_stage = STG_RELEASE;
            end
        end
    end

    always_comb
    begin
        level_next = trig_level;
        hold_next  = trig_hold;
        stage_next = trig_stage;
        ramp = '0;
        case (trig_stage)
            STG_ATTACK1:
            begin
                ramp = ramp_toward(trig_level, attack_one_reg[15:8], attack_one_reg[7:0]);
                level_next = ramp.level;
                if (ramp.reached) stage_next = STG_ATTACK2;
            end
            STG_ATTACK2:
            begin
                ramp = ramp_toward(trig_level, attack_two_reg[15:8], attack_two_reg[7:0]);
                level_next = ramp.level;
                if (ramp.reached) stage_next = STG_DECAY;
            end
            STG_DECAY:
            begin
                ramp = ramp_toward(trig_level, decay_reg[15:8], decay_reg[7:0]);
                level_next = ramp.level;
                if (ramp.reached) stage_next = STG_SUSTAIN;
            end
            STG_SUSTAIN:
            begin
                if (trig_hold != '0) hold_next = trig_hold - hold_t'(1);
                else                 stage_next = STG_RELEASE;
            end
            STG_RELEASE:
            begin
                ramp = ramp_toward(trig_level, '0, release_step_reg);
                level_next = ramp.level;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            hold_reg  <= '0;
            stage_reg <= STG_RELEASE;
        end
        else if (accept)
        begin
            level_reg <= level_next;
            hold_reg  <= hold_next;
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || take) out_valid_reg <= 1'b1;
            else                        skid_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_level_reg <= skid_level_reg;
                out_stage_reg <= skid_stage_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_level_reg <= level_next;
                out_stage_reg <= stage_next;
            end
            else
            begin
                skid_level_reg <= level_next;
                skid_stage_reg <= stage_next;
            end
        end
    end

endmodule

/* design/amenv_checker.sv */
module amenv_checker
    import amenv_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       tick_valid,
    input logic       tick_ready,
    input logic       tick_row_start,
    input logic       tick_note_event,
    input logic       tick_slide_to_note,
    input logic       env_valid,
    input logic       env_ready,
    input level_t     env_volume,
    input logic [2:0] env_phase
);

    logic tick_accept;
    logic note_trig;

    assign tick_accept = tick_valid && tick_ready;
    assign note_trig = tick_row_start && tick_note_event && !tick_slide_to_note;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        env_valid && !env_ready |=> env_valid && $stable(env_volume) && $stable(env_phase))
        else $error("result changed while stalled");

    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        env_valid |-> env_phase <= STG_RELEASE)
        else $error("stage code out of range");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_ready |-> env_valid)
        else $error("tick stalled with empty output");

    a_note_attack: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept && note_trig && !env_valid |=>
            env_valid && (env_phase == STG_ATTACK1 || env_phase == STG_ATTACK2))
        else $error("note trigger did not start attack");

endmodule

bind am_envelope_generator_unit amenv_checker u_amenv_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .tick_valid         (tick.valid),
    .tick_ready         (tick.ready),
    .tick_row_start     (tick.row_start),
    .tick_note_event    (tick.note_event),
    .tick_slide_to_note (tick.slide_to_note),
    .env_valid          (env.valid),
    .env_ready          (env.ready),
    .env_volume         (env.envelope_volume),
    .env_phase          (env.envelope_stage)
);
